FILE: src/esk_pkg.sv
// Shared types and operation codes for the event stack with key removal.
`default_nettype none
package esk_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  channel;
        logic [15:0] key;
        logic [63:0] stamp;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [31:0] word_d;
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam int unsigned FILL_W = 5;

endpackage
`default_nettype wire

FILE: src/esk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module esk_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: src/event_stack_with_key_removal_top.sv
// Event stack with key removal: sequencer, key comparator, slot RAM and result register.
// Push and pop pass to the done state, which registers their result when the output is free.
// Remove scans the stored events through one RAM read port and one key comparator,
// writing every event whose key does not match back in order, then registers its result.
// One operation is in flight at a time; the next beat is accepted in the cycle after the result
// is registered, and a stalled result holds the sequencer until the output register is free.
// Reset (rst_n low, asynchronous) empties the stack; slot contents need no clearing pass.
`default_nettype none
module event_stack_with_key_removal_top #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [3:0]  event_kind,
    input  wire logic [7:0]  event_channel,
    input  wire logic [15:0] event_key,
    input  wire logic [63:0] event_stamp,
    input  wire logic [31:0] value_a,
    input  wire logic [31:0] value_b,
    input  wire logic [31:0] value_c,
    input  wire logic [31:0] value_d,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             popped_valid,
    output logic [3:0]       out_kind,
    output logic [7:0]       out_channel,
    output logic [15:0]      out_key,
    output logic [63:0]      out_stamp,
    output logic [31:0]      out_value_a,
    output logic [31:0]      out_value_b,
    output logic [31:0]      out_value_c,
    output logic [31:0]      out_value_d,
    output logic [4:0]       fill_level,
    output logic             push_dropped
);
    import esk_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned EW = $bits(event_t);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CW-1:0]   keep_reg, keep_next;
    logic            pend_reg, pend_next;
    logic            popped_reg, popped_next;
    logic            dropped_reg, dropped_next;
    logic [15:0]     key_reg, key_next;

    logic            out_valid_reg, out_valid_next;
    event_t          out_event_reg, out_event_next;
    logic            out_popped_reg, out_popped_next;
    logic            out_dropped_reg, out_dropped_next;
    logic [4:0]      out_fill_reg, out_fill_next;

    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    event_t          ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    event_t          ram_rd_data;
    event_t          in_event;
    logic            accept;
    logic            key_match;
    logic [CW-1:0]   count_dec;

    assign in_event = '{kind: event_kind, channel: event_channel, key: event_key,
                        stamp: event_stamp, word_a: value_a, word_b: value_b,
                        word_c: value_c, word_d: value_d};

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign key_match = (ram_rd_data.key == key_reg);
    assign count_dec = count_reg - CW'(1);

    esk_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        keep_next        = keep_reg;
        pend_next        = pend_reg;
        popped_next      = popped_reg;
        dropped_next     = dropped_reg;
        key_next         = key_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_event_next   = out_event_reg;
        out_popped_next  = out_popped_reg;
        out_dropped_next = out_dropped_reg;
        out_fill_next    = out_fill_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = count_reg[AW-1:0];
        ram_wr_data      = in_event;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = count_dec[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next     = event_key;
                    popped_next  = 1'b0;
                    dropped_next = 1'b0;
                    rd_idx_next  = '0;
                    keep_next    = '0;
                    pend_next    = 1'b0;
                    state_next   = ST_DONE;
                    unique case (op_t'(operation))
                        OP_PUSH:
                        begin
                            if (count_reg < CW'(STACK_DEPTH))
                            begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                count_next  = count_dec;
                                popped_next = 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        OP_NONE:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && !key_match)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = keep_reg[AW-1:0];
                    ram_wr_data = ram_rd_data;
                    keep_next   = keep_reg + CW'(1);
                end
                if (rd_idx_reg < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (!pend_reg && (rd_idx_reg == count_reg))
                begin
                    count_next = keep_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_event_next   = popped_reg ? ram_rd_data : '0;
                    out_popped_next  = popped_reg;
                    out_dropped_next = dropped_reg;
                    out_fill_next    = FILL_W'(count_reg);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            keep_reg      <= '0;
            pend_reg      <= 1'b0;
            popped_reg    <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            keep_reg      <= keep_next;
            pend_reg      <= pend_next;
            popped_reg    <= popped_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg         <= key_next;
        out_event_reg   <= out_event_next;
        out_popped_reg  <= out_popped_next;
        out_dropped_reg <= out_dropped_next;
        out_fill_reg    <= out_fill_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_valid = out_popped_reg;
    assign out_kind     = out_event_reg.kind;
    assign out_channel  = out_event_reg.channel;
    assign out_key      = out_event_reg.key;
    assign out_stamp    = out_event_reg.stamp;
    assign out_value_a  = out_event_reg.word_a;
    assign out_value_b  = out_event_reg.word_b;
    assign out_value_c  = out_event_reg.word_c;
    assign out_value_d  = out_event_reg.word_d;
    assign fill_level   = out_fill_reg;
    assign push_dropped = out_dropped_reg;

endmodule
`default_nettype wire

FILE: src/esk_checker.sv
// Port-level assertions for the event stack with key removal, bound to the top level.
`default_nettype none
module esk_checker #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        popped_valid,
    input wire logic [3:0]  out_kind,
    input wire logic [63:0] out_stamp,
    input wire logic [4:0]  fill_level,
    input wire logic        push_dropped
);
    import esk_pkg::*;

    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(STACK_DEPTH);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fill_level) && $stable(popped_valid))
        else $error("result changed while stalled");

    a_pop_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && popped_valid |-> !push_dropped)
        else $error("pop result flagged as dropped push");

    a_null_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !popped_valid |-> (out_kind == 4'd0) && (out_stamp == 64'd0))
        else $error("non-pop result carries event data");

    a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && push_dropped |-> fill_level == FULL_FILL)
        else $error("push dropped while stack not full");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (STACK_DEPTH > 31) || (fill_level <= FULL_FILL))
        else $error("fill level beyond stack depth");

endmodule

bind event_stack_with_key_removal_top esk_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_esk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_valid (popped_valid),
    .out_kind     (out_kind),
    .out_stamp    (out_stamp),
    .fill_level   (fill_level),
    .push_dropped (push_dropped)
);
`default_nettype wire
